// ===== hdl/gp_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// gp_pkg
// Shared constants, types and the arctangent table for the gnomonic
// projection pipeline.
// ---------------------------------------------------------------------------
package gp_pkg;

    localparam int ANGLE_BITS_DEF      = 16;
    localparam int COORD_FRAC_BITS_DEF = 24;

    localparam int CORDIC_STEPS = 30;
    localparam int TRIG_W       = 34;            // Q2.30 with headroom
    localparam int PROD_W       = 36;
    localparam int SUM_W        = 37;
    localparam int QUO_W        = 32;
    localparam int REM_W        = SUM_W + QUO_W; // covers frac bits up to 31
    localparam int ZW           = 33;

    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [SUM_W-1:0]  TINY        = 37'sd1074;

    localparam logic [1:0] ST_NORMAL   = 2'd0;
    localparam logic [1:0] ST_TINY_POS = 2'd1;
    localparam logic [1:0] ST_TINY_NEG = 2'd2;
    localparam logic [1:0] ST_BEHIND   = 2'd3;

    typedef logic signed [TRIG_W-1:0] t_trig;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [ZW-1:0]     t_zang;
    typedef logic [REM_W-1:0]         t_rem;

    // atan(2^-i) in units of 2^-32 turn
    function automatic t_zang cordic_atan(input int i);
        t_zang v;
        case (i)
            0:  v = 33'sd536870912;
            1:  v = 33'sd316933406;
            2:  v = 33'sd167458907;
            3:  v = 33'sd85004756;
            4:  v = 33'sd42667331;
            5:  v = 33'sd21354465;
            6:  v = 33'sd10680862;
            7:  v = 33'sd5340245;
            8:  v = 33'sd2670163;
            9:  v = 33'sd1335087;
            10: v = 33'sd667544;
            11: v = 33'sd333772;
            12: v = 33'sd166886;
            13: v = 33'sd83443;
            14: v = 33'sd41722;
            15: v = 33'sd20861;
            16: v = 33'sd10430;
            17: v = 33'sd5215;
            18: v = 33'sd2608;
            19: v = 33'sd1304;
            20: v = 33'sd652;
            21: v = 33'sd326;
            22: v = 33'sd163;
            23: v = 33'sd81;
            24: v = 33'sd41;
            25: v = 33'sd20;
            26: v = 33'sd10;
            27: v = 33'sd5;
            28: v = 33'sd3;
            29: v = 33'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/gnomonic_projection.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// gnomonic_projection
// Tangent plane projection of a sky direction around a configured point.
// ---------------------------------------------------------------------------
// Fully pipelined: one item per cycle while the output is not stalled. The
// pipeline holds the 30-step CORDIC (three lanes in parallel: star dec,
// tangent dec, RA difference), two multiply stages and a 32-stage restoring
// divider (one quotient bit per stage, x and y in parallel). A stall on the
// output freezes the whole pipeline. Registers: 0x0 tangent_ra, 0x4
// tangent_dec; write only while no item is in flight.
module gnomonic_projection #(
    parameter int ANGLE_BITS      = gp_pkg::ANGLE_BITS_DEF,
    parameter int COORD_FRAC_BITS = gp_pkg::COORD_FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // star_ra [ANGLE_BITS-1:0], star_dec above it
    input  wire logic [((2*ANGLE_BITS+7)/8)*8-1:0]   s_axis_tdata,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // plane_x [31:0], plane_y [63:32]
    output logic [63:0]                              m_axis_tdata,
    // status [1:0], clipped [2]
    output logic [2:0]                               m_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [2:0]                          paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);
    import gp_pkg::*;

    localparam int NSTG = CORDIC_STEPS + 39;
    localparam int DIVS = QUO_W;

    logic en;
    logic [NSTG-1:0] r_vld;
    logic [ANGLE_BITS-1:0] r_tra, r_tdec;

    assign en            = !r_vld[NSTG-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[NSTG-1];
    assign pready        = 1'b1;
    assign prdata = paddr[2] ? 32'($signed(r_tdec)) : 32'(r_tra);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_tra  <= '0;
            r_tdec <= '0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[NSTG-2:0], s_axis_tvalid};
            end
            if (psel && penable && pwrite) begin
                if (paddr[2]) begin
                    r_tdec <= pwdata[ANGLE_BITS-1:0];
                end else begin
                    r_tra <= pwdata[ANGLE_BITS-1:0];
                end
            end
        end
    end

    // ---- quadrant fold ----
    logic [31:0] ang [3];
    logic [ANGLE_BITS-1:0] dra;
    t_zang r_fz [3];
    logic [1:0] r_fq [3];

    assign dra    = s_axis_tdata[ANGLE_BITS-1:0] - r_tra;
    assign ang[0] = {s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS], {(32-ANGLE_BITS){1'b0}}};
    assign ang[1] = {r_tdec, {(32-ANGLE_BITS){1'b0}}};
    assign ang[2] = {dra, {(32-ANGLE_BITS){1'b0}}};

    genvar gl, gk;
    generate
        for (gl = 0; gl < 3; gl++) begin : g_fold
            logic [31:0] t, r;
            assign t = ang[gl] + 32'h2000_0000;
            assign r = ang[gl] - {t[31:30], 30'd0};
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_fq[gl] <= t[31:30];
                    r_fz[gl] <= $signed({r[31], r});
                end
            end
        end
    endgenerate

    // ---- CORDIC rotation stages ----
    t_trig w_x [CORDIC_STEPS+1][3];
    t_trig w_y [CORDIC_STEPS+1][3];
    t_zang w_z [CORDIC_STEPS+1][3];
    logic [1:0] w_q [CORDIC_STEPS+1][3];
    t_trig r_x [CORDIC_STEPS][3];
    t_trig r_y [CORDIC_STEPS][3];
    t_zang r_z [CORDIC_STEPS][3];
    logic [1:0] r_q [CORDIC_STEPS][3];

    generate
        for (gl = 0; gl < 3; gl++) begin : g_init
            assign w_x[0][gl] = CORDIC_GAIN;
            assign w_y[0][gl] = '0;
            assign w_z[0][gl] = r_fz[gl];
            assign w_q[0][gl] = r_fq[gl];
        end
        for (gk = 0; gk < CORDIC_STEPS; gk++) begin : g_cor
            localparam t_zang ATN = cordic_atan(gk);
            for (gl = 0; gl < 3; gl++) begin : g_lane
                t_trig dx, dy;
                assign dx = w_y[gk][gl] >>> gk;
                assign dy = w_x[gk][gl] >>> gk;
                assign w_x[gk+1][gl] = r_x[gk][gl];
                assign w_y[gk+1][gl] = r_y[gk][gl];
                assign w_z[gk+1][gl] = r_z[gk][gl];
                assign w_q[gk+1][gl] = r_q[gk][gl];
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_q[gk][gl] <= w_q[gk][gl];
                        if (!w_z[gk][gl][ZW-1]) begin
                            r_x[gk][gl] <= w_x[gk][gl] - dx;
                            r_y[gk][gl] <= w_y[gk][gl] + dy;
                            r_z[gk][gl] <= w_z[gk][gl] - ATN;
                        end else begin
                            r_x[gk][gl] <= w_x[gk][gl] + dx;
                            r_y[gk][gl] <= w_y[gk][gl] - dy;
                            r_z[gk][gl] <= w_z[gk][gl] + ATN;
                        end
                    end
                end
            end
        end
    endgenerate

    // ---- quadrant unfold: lane 0 star dec, 1 tangent dec, 2 RA difference ----
    t_trig r_s [3];
    t_trig r_c [3];

    generate
        for (gl = 0; gl < 3; gl++) begin : g_unfold
            t_trig x, y;
            assign x = w_x[CORDIC_STEPS][gl];
            assign y = w_y[CORDIC_STEPS][gl];
            always_ff @(posedge i_clk) begin
                if (en) begin
                    case (w_q[CORDIC_STEPS][gl])
                        2'd0: begin r_c[gl] <= x;  r_s[gl] <= y;  end
                        2'd1: begin r_c[gl] <= -y; r_s[gl] <= x;  end
                        2'd2: begin r_c[gl] <= -x; r_s[gl] <= -y; end
                        default: begin r_c[gl] <= y; r_s[gl] <= -x; end
                    endcase
                end
            end
        end
    endgenerate

    // ---- first products ----
    logic signed [2*TRIG_W-1:0] m1, m2, m3, m4, m5;
    t_prod r_p1, r_p2, r_p3, r_p4, r_p5;
    t_trig r_b_cdr;

    assign m1 = r_s[0] * r_s[1];
    assign m2 = r_c[0] * r_c[1];
    assign m3 = r_c[0] * r_s[2];
    assign m4 = r_s[0] * r_c[1];
    assign m5 = r_c[0] * r_s[1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1    <= $signed(m1[30 +: PROD_W]);
            r_p2    <= $signed(m2[30 +: PROD_W]);
            r_p3    <= $signed(m3[30 +: PROD_W]);
            r_p4    <= $signed(m4[30 +: PROD_W]);
            r_p5    <= $signed(m5[30 +: PROD_W]);
            r_b_cdr <= r_c[2];
        end
    end

    // ---- triple products ----
    logic signed [PROD_W+TRIG_W-1:0] m6, m7;
    t_prod r_c_p1, r_c_p3, r_c_p4, r_p6, r_p7;

    assign m6 = r_p2 * r_b_cdr;
    assign m7 = r_p5 * r_b_cdr;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p6   <= $signed(m6[30 +: PROD_W]);
            r_p7   <= $signed(m7[30 +: PROD_W]);
            r_c_p1 <= r_p1;
            r_c_p3 <= r_p3;
            r_c_p4 <= r_p4;
        end
    end

    // ---- denominator, clamp, signs ----
    t_sum den_raw, den, xn, yn;
    logic [1:0] st;
    logic [SUM_W-1:0] r_d_unx, r_d_uny, r_d_ud;
    logic r_d_negx, r_d_negy;
    logic [1:0] r_d_st;

    always_comb begin
        den_raw = t_sum'(r_c_p1) + t_sum'(r_p6);
        yn      = t_sum'(r_c_p4) - t_sum'(r_p7);
        xn      = t_sum'(r_c_p3);
        den     = den_raw;
        if (den_raw > TINY) begin
            st = ST_NORMAL;
        end else if (!den_raw[SUM_W-1]) begin
            st  = ST_TINY_POS;
            den = TINY;
        end else if (den_raw > -TINY) begin
            st  = ST_TINY_NEG;
            den = -TINY;
        end else begin
            st = ST_BEHIND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_st   <= st;
            r_d_negx <= xn[SUM_W-1] ^ den[SUM_W-1];
            r_d_negy <= yn[SUM_W-1] ^ den[SUM_W-1];
            r_d_unx  <= xn[SUM_W-1] ? -xn : xn;
            r_d_uny  <= yn[SUM_W-1] ? -yn : yn;
            r_d_ud   <= den[SUM_W-1] ? -den : den;
        end
    end

    // ---- restoring divider, one quotient bit per stage ----
    t_rem r_rem [DIVS+1][2];
    logic [QUO_W-1:0] r_quo [DIVS+1][2];
    logic r_neg [DIVS+1][2];
    logic r_ovf [DIVS+1][2];
    logic [SUM_W-1:0] r_dd [DIVS+1];
    logic [1:0] r_st [DIVS+1];

    t_rem n0 [2];
    t_rem dd_top;
    assign n0[0]  = t_rem'(r_d_unx) << COORD_FRAC_BITS;
    assign n0[1]  = t_rem'(r_d_uny) << COORD_FRAC_BITS;
    assign dd_top = t_rem'(r_d_ud) << QUO_W;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dd[0]     <= r_d_ud;
            r_st[0]     <= r_d_st;
            r_neg[0][0] <= r_d_negx;
            r_neg[0][1] <= r_d_negy;
            for (int l = 0; l < 2; l++) begin
                r_rem[0][l] <= n0[l];
                r_quo[0][l] <= '0;
                r_ovf[0][l] <= n0[l] >= dd_top;
            end
        end
    end

    generate
        for (gk = 0; gk < DIVS; gk++) begin : g_div
            t_rem sub;
            assign sub = t_rem'(r_dd[gk]) << (DIVS-1-gk);
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dd[gk+1] <= r_dd[gk];
                    r_st[gk+1] <= r_st[gk];
                end
            end
            for (gl = 0; gl < 2; gl++) begin : g_lane
                logic ge;
                assign ge = r_rem[gk][gl] >= sub;
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_neg[gk+1][gl] <= r_neg[gk][gl];
                        r_ovf[gk+1][gl] <= r_ovf[gk][gl];
                        r_rem[gk+1][gl] <= ge ? r_rem[gk][gl] - sub : r_rem[gk][gl];
                        r_quo[gk+1][gl] <= {r_quo[gk][gl][QUO_W-2:0], ge};
                    end
                end
            end
        end
    endgenerate

    // ---- sign, saturation, output register ----
    logic [31:0] res [2];
    logic        clp [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (r_neg[DIVS][l]) begin
                clp[l] = r_ovf[DIVS][l] ||
                         (r_quo[DIVS][l][31] && (|r_quo[DIVS][l][30:0]));
                res[l] = clp[l] ? 32'h8000_0000 : -r_quo[DIVS][l];
            end else begin
                clp[l] = r_ovf[DIVS][l] || r_quo[DIVS][l][31];
                res[l] = clp[l] ? 32'h7FFF_FFFF : r_quo[DIVS][l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            m_axis_tdata <= {res[1], res[0]};
            m_axis_tuser <= {clp[0] || clp[1], r_st[DIVS]};
        end
    end

endmodule
`default_nettype wire

// ===== test/gnomonic_projection_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gnomonic_projection_tb
// Self-checking bench for the tangent plane projection pipeline. Each item
// taken by the block is projected by a bit-exact model (CORDIC, Q2.30
// products, saturating divide) and the prediction is compared with the
// result stream. Several tangent points are set through the register port,
// and the stream sides idle at random.
// ---------------------------------------------------------------------------
module gnomonic_projection_tb;
    import gp_pkg::*;

    localparam longint GAIN_Q30 = 652032874;
    localparam longint TINY_Q30 = 1074;
    localparam longint ATAN_TURN32 [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1};
    localparam logic [2:0] ADDR_TANGENT_RA  = 3'd0;
    localparam logic [2:0] ADDR_TANGENT_DEC = 3'd4;

    typedef struct {
        logic [31:0] plane_x;
        logic [31:0] plane_y;
        logic [1:0]  status;
        logic        clipped;
    } t_proj;

    class proj_scoreboard;
        logic [15:0] tan_ra = '0;
        logic [15:0] tan_dec = '0;
        t_proj       pending[$];
        int          mismatches = 0;
        int          results = 0;
        int          status_seen[4] = '{0, 0, 0, 0};
        int          clips = 0;

        function automatic longint mul_q30(longint a, longint b);
            return (a * b) >>> 30;
        endfunction

        function automatic void sin_cos(logic [31:0] ang, output longint s,
                                        output longint c);
            logic [31:0] t;
            logic [1:0]  q;
            logic [31:0] r;
            longint      x, y, z, dx, dy;
            t = ang + 32'h2000_0000;
            q = t[31:30];
            r = ang - {q, 30'b0};
            z = longint'($signed(r));
            x = GAIN_Q30;
            y = 0;
            for (int i = 0; i < 30; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= ATAN_TURN32[i];
                end else begin
                    x += dx; y -= dy; z += ATAN_TURN32[i];
                end
            end
            case (q)
                2'd0: begin c = x;  s = y;  end
                2'd1: begin c = -y; s = x;  end
                2'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
        endfunction

        function automatic longint div_sat(longint num, longint den, inout bit clip);
            bit     neg;
            longint un, ud, q;
            neg = (num < 0) != (den < 0);
            un = (num < 0) ? -num : num;
            ud = (den < 0) ? -den : den;
            if (ud == 0) ud = 1;
            q = (un << 24) / ud;
            if (neg) begin
                if (q > 64'sd2147483648) begin
                    clip = 1;
                    return -64'sd2147483648;
                end
                return -q;
            end
            if (q > 64'sd2147483647) begin
                clip = 1;
                return 64'sd2147483647;
            end
            return q;
        endfunction

        function void note(logic [15:0] ra, logic [15:0] dec);
            longint      sd, cd, s0, c0, sr, cr, den, xn, yn;
            logic [15:0] dra;
            bit          clip;
            t_proj       e;
            clip = 0;
            dra = ra - tan_ra;
            sin_cos({dec, 16'b0}, sd, cd);
            sin_cos({tan_dec, 16'b0}, s0, c0);
            sin_cos({dra, 16'b0}, sr, cr);
            den = mul_q30(sd, s0) + mul_q30(mul_q30(cd, c0), cr);
            if (den > TINY_Q30) begin
                e.status = ST_NORMAL;
            end else if (den >= 0) begin
                e.status = ST_TINY_POS; den = TINY_Q30;
            end else if (den > -TINY_Q30) begin
                e.status = ST_TINY_NEG; den = -TINY_Q30;
            end else begin
                e.status = ST_BEHIND;
            end
            xn = mul_q30(cd, sr);
            yn = mul_q30(sd, c0) - mul_q30(mul_q30(cd, s0), cr);
            e.plane_x = div_sat(xn, den, clip);
            e.plane_y = div_sat(yn, den, clip);
            e.clipped = clip;
            pending.push_back(e);
        endfunction

        function void check(logic [63:0] data, logic [2:0] user);
            t_proj e;
            results++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h / %h", data, user);
                return;
            end
            e = pending.pop_front();
            status_seen[e.status]++;
            clips += e.clipped;
            if (data[31:0] !== e.plane_x || data[63:32] !== e.plane_y
                    || user[1:0] !== e.status || user[2] !== e.clipped) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result %0d: exp x=%h y=%h st=%0d clip=%0d,",
                              " got x=%h y=%h st=%0d clip=%0d"},
                             results, e.plane_x, e.plane_y, e.status, e.clipped,
                             data[31:0], data[63:32], user[1:0], user[2]);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic [31:0] s_axis_tdata = '0;   // star_ra [15:0], star_dec [31:16]
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] m_axis_tdata;        // plane_x [31:0], plane_y [63:32]
    logic [2:0]  m_axis_tuser;        // status [1:0], clipped [2]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int tx_idle = 0;
    int rx_idle = 0;
    int sent = 0;
    proj_scoreboard sb = new();

    gnomonic_projection DUT (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check(m_axis_tdata, m_axis_tuser);
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= addr; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_TANGENT_RA) sb.tan_ra = value[15:0];
        else sb.tan_dec = value[15:0];
    endtask

    // random upper bits check that only the angle bits are taken
    task automatic set_tangent(logic [15:0] ra, logic [15:0] dec);
        reg_write(ADDR_TANGENT_RA, {16'($urandom_range(65535)), ra});
        reg_write(ADDR_TANGENT_DEC, {16'($urandom_range(65535)), dec});
    endtask

    task automatic send(logic [15:0] ra, logic [15:0] dec);
        while ($urandom_range(99) < tx_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {dec, ra};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note(ra, dec);
        sent++;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_dec();
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    initial begin
        logic [15:0] ra, dec;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, limb of the plane (tiny denominators),
        // far side, large ratios that saturate, declinations past the pole
        set_tangent(16'd0, 16'd0);
        send(16'd0, 16'd0);
        send(16'd65535, 16'd0);
        send(16'd0, 16'sd16384);
        send(16'd0, -16'sd16384);
        send(16'd16384, 16'd0);
        send(16'd49152, 16'd0);
        send(16'd16383, 16'd0);
        send(16'd16385, 16'd0);
        send(16'd49151, 16'd0);
        send(16'd49153, 16'd0);
        send(16'd32768, 16'd0);
        send(16'd32768, 16'sd100);
        send(16'd16000, 16'd0);
        send(16'd0, 16'sd16000);
        send(16'd0, -16'sd16000);
        send(16'd16384, 16'sd1);
        send(16'd0, 16'h8000);
        send(16'd0, 16'h7fff);
        send(16'd65535, 16'hffff);
        send(16'd12345, 16'h4001);
        s_axis_tvalid <= 1'b0;
        drain();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_tangent(16'd65535, 16'sd16384);
                1: set_tangent(16'd12345, -16'sd16384);
                2: set_tangent(16'd32768, rand_dec());
                3: set_tangent(16'($urandom_range(65535)), 16'd0);
                4: set_tangent(16'($urandom_range(65535)), 16'h9abc);
                default: set_tangent(16'($urandom_range(65535)), rand_dec());
            endcase
            case (p % 3)
                0: begin tx_idle = 31; rx_idle = 50; end
                1: begin tx_idle = 50; rx_idle = 31; end
                default: begin tx_idle = 0; rx_idle = 0; end
            endcase
            for (int n = 0; n < 90; n++) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: begin
                        // near the tangent point: the ordinary case
                        ra = sb.tan_ra + 16'($signed($urandom_range(8000)) - 4000);
                        dec = sb.tan_dec + 16'($signed($urandom_range(8000)) - 4000);
                    end
                    5, 6: begin
                        // near the limb, where the denominator is tiny
                        ra = sb.tan_ra + ($urandom_range(1) ? 16'd16384 : 16'd49152)
                             + 16'($signed($urandom_range(6)) - 3);
                        dec = sb.tan_dec;
                    end
                    7, 8: begin
                        ra = 16'($urandom_range(65535));
                        dec = rand_dec();
                    end
                    default: begin
                        ra = 16'($urandom_range(65535));
                        dec = 16'($urandom_range(65535));
                    end
                endcase
                send(ra, dec);
                // stretch with no idling mid-phase
                if (n == 45 && p % 3 != 2) begin
                    tx_idle = 0; rx_idle = 0;
                end
            end
            s_axis_tvalid <= 1'b0;
            drain();
        end

        rx_idle = 0;
        drain();
        $display("%0d items projected over 7 tangent points", sent);
        $display("status counts %0d/%0d/%0d/%0d, %0d clipped",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
                 sb.status_seen[3], sb.clips);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d results outstanding", sb.mismatches,
                     sb.pending.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
    end
endmodule
